// File: rtl/core/gha_pkg.sv
// Shared types and constants for the generational handle allocator.
// No dependencies; the allocator unit and the testbench import it, gha_ram does not.
package gha_pkg;

   // Field widths of handles, counters and the register port.
   localparam int IDX_W     = 12;
   localparam int GEN_W     = 8;
   localparam int WORLD_W   = 8;
   localparam int CNT_W     = IDX_W + 1;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;
   localparam int PADDR_W   = 3;
   localparam int PDATA_W   = 32;
   localparam int MAX_SLOTS = 1 << IDX_W;

   // Reset value of the reuse threshold register.
   localparam logic [CNT_W-1:0] THRESH_RESET = CNT_W'(1024);

   // Register select, taken from the word address bit of paddr.
   localparam logic REG_WORLD_ID        = 1'b0;
   localparam logic REG_REUSE_THRESHOLD = 1'b1;

   // Operation codes of an input item.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DEALLOC = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CHECK   = 2'd2;

   // Status codes of a result item.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 2'd2;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP
   } state_type;

endpackage

// File: rtl/core/generational_handle_allocator_unit.sv
// Generational handle allocator. An item is taken when start is high and busy
// is low; its one result appears on the rsp_ ports for exactly one cycle, marked
// by rsp_valid, and cannot be held off by the receiver. Allocate of a fresh
// index, deallocate and check go through one memory read, then the update and
// write back in ST_EXEC; an allocate that reuses a queued index also passes
// ST_POP, because the generation read depends on the index read from the free
// queue. busy falls as the result comes out, so the next item may be taken in
// the same cycle as the result. Both memories need no clearing pass after
// reset. Registers sit at byte address 0 (world_id) and 4 (reuse_threshold)
// and are to be written only while the block is idle; it does not enforce this.
module generational_handle_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   // Command channel.
   input  logic                            start,
   output logic                            busy,
   input  logic [gha_pkg::FUNC_W-1:0]      req_func,
   input  logic [gha_pkg::IDX_W-1:0]       req_handle_index,
   input  logic [gha_pkg::GEN_W-1:0]       req_handle_generation,
   input  logic [gha_pkg::WORLD_W-1:0]     req_handle_world,
   // Result channel.
   output logic                            rsp_valid,
   output logic [gha_pkg::STATUS_W-1:0]    rsp_status,
   output logic [gha_pkg::IDX_W-1:0]       rsp_out_index,
   output logic [gha_pkg::GEN_W-1:0]       rsp_out_generation,
   output logic [gha_pkg::WORLD_W-1:0]     rsp_out_world,
   output logic                            rsp_reused,
   output logic                            rsp_is_valid,
   // Register port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [gha_pkg::PADDR_W-1:0]     paddr,
   input  logic [gha_pkg::PDATA_W-1:0]     pwdata,
   output logic [gha_pkg::PDATA_W-1:0]     prdata,
   output logic                            pready
);

   import gha_pkg::*;

   // Control state.
   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     slots_ff, slots_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [WORLD_W-1:0]   world_id_ff;
   logic [CNT_W-1:0]     thresh_ff;

   // Latched item.
   logic [FUNC_W-1:0]    func_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [GEN_W-1:0]     gen_ff;
   logic [WORLD_W-1:0]   world_ff;
   logic [IDX_W-1:0]     pop_idx_ff;

   // Result registers.
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]     rsp_index_ff, rsp_index_in;
   logic [GEN_W-1:0]     rsp_gen_ff, rsp_gen_in;
   logic [WORLD_W-1:0]   rsp_world_ff, rsp_world_in;
   logic                 rsp_reused_ff, rsp_reused_in;
   logic                 rsp_is_valid_ff, rsp_is_valid_in;

   // Memory ports.
   logic                 gen_we;
   logic [IDX_W-1:0]     gen_waddr;
   logic [GEN_W-1:0]     gen_wdata;
   logic [IDX_W-1:0]     gen_raddr;
   logic [GEN_W-1:0]     gen_rdata;
   logic                 fifo_we;
   logic [IDX_W-1:0]     fifo_rdata;

   logic                 accept;
   logic                 cfg_write;
   logic                 handle_ok;
   logic                 fresh_left;
   logic                 take_fresh;
   logic                 queue_full;

   assign accept    = start && (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign cfg_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   // Generation store, one entry per slot.
   gha_ram #(.DATA_W(GEN_W), .ADDR_W(IDX_W)) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_we),
      .wr_addr (gen_waddr),
      .wr_data (gen_wdata),
      .rd_addr (gen_raddr),
      .rd_data (gen_rdata)
   );

   // Free queue of released indices; the head entry is read every cycle.
   gha_ram #(.DATA_W(IDX_W), .ADDR_W(IDX_W)) u_fifo_ram (
      .clock   (clock),
      .wr_en   (fifo_we),
      .wr_addr (tail_ff),
      .wr_data (idx_ff),
      .rd_addr (head_ff),
      .rd_data (fifo_rdata)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         world_id_ff <= '0;
         thresh_ff   <= THRESH_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == REG_WORLD_ID) begin
            world_id_ff <= pwdata[WORLD_W-1:0];
         end else begin
            thresh_ff <= pwdata[CNT_W-1:0];
         end
      end
   end

   // Register read back.
   always_comb begin
      if (paddr[2] == REG_REUSE_THRESHOLD) begin
         prdata = {{(PDATA_W-CNT_W){1'b0}}, thresh_ff};
      end else begin
         prdata = {{(PDATA_W-WORLD_W){1'b0}}, world_id_ff};
      end
   end

   // Handle validity and allocation choice, evaluated once the memory data is in.
   assign handle_ok  = (world_ff == world_id_ff) && ({1'b0, idx_ff} < slots_ff) &&
                       (gen_ff == gen_rdata);
   assign fresh_left = (slots_ff < CNT_W'(MAX_SLOTS));
   assign take_fresh = ((count_ff < thresh_ff) || (count_ff == '0)) && fresh_left;
   assign queue_full = (count_ff >= CNT_W'(MAX_SLOTS));

   // Sequencer: next state, counters, memory writes and the result.
   always_comb begin
      state_in        = state_ff;
      slots_in        = slots_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      gen_we          = 1'b0;
      gen_waddr       = idx_ff;
      gen_wdata       = gen_rdata + GEN_W'(1);
      gen_raddr       = req_handle_index;
      fifo_we         = 1'b0;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = STATUS_INVALID;
      rsp_index_in    = idx_ff;
      rsp_gen_in      = '0;
      rsp_world_in    = '0;
      rsp_reused_in   = 1'b0;
      rsp_is_valid_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            gen_raddr = fifo_rdata;
            state_in  = ST_IDLE;
            case (func_ff)
               FUNC_ALLOC: begin
                  if (take_fresh) begin
                     gen_we          = 1'b1;
                     gen_waddr       = slots_ff[IDX_W-1:0];
                     gen_wdata       = '0;
                     slots_in        = slots_ff + CNT_W'(1);
                     rsp_valid_in    = 1'b1;
                     rsp_status_in   = STATUS_OK;
                     rsp_index_in    = slots_ff[IDX_W-1:0];
                     rsp_world_in    = world_id_ff;
                     rsp_is_valid_in = 1'b1;
                  end else if (count_ff != '0) begin
                     // Pop the oldest queued index, then fetch its generation.
                     head_in  = head_ff + IDX_W'(1);
                     count_in = count_ff - CNT_W'(1);
                     state_in = ST_POP;
                  end else begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = STATUS_FULL;
                  end
               end
               FUNC_DEALLOC: begin
                  rsp_valid_in = 1'b1;
                  if (!handle_ok) begin
                     rsp_status_in = STATUS_INVALID;
                  end else if (queue_full) begin
                     rsp_status_in   = STATUS_FULL;
                     rsp_is_valid_in = 1'b1;
                  end else begin
                     fifo_we         = 1'b1;
                     tail_in         = tail_ff + IDX_W'(1);
                     count_in        = count_ff + CNT_W'(1);
                     gen_we          = 1'b1;
                     rsp_status_in   = STATUS_OK;
                     rsp_is_valid_in = 1'b1;
                  end
               end
               FUNC_CHECK: begin
                  rsp_valid_in    = 1'b1;
                  rsp_is_valid_in = handle_ok;
                  rsp_status_in   = handle_ok ? STATUS_OK : STATUS_INVALID;
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
         end
         ST_POP: begin
            state_in        = ST_IDLE;
            rsp_valid_in    = 1'b1;
            rsp_status_in   = STATUS_OK;
            rsp_index_in    = pop_idx_ff;
            rsp_gen_in      = gen_rdata;
            rsp_world_in    = world_id_ff;
            rsp_reused_in   = 1'b1;
            rsp_is_valid_in = 1'b1;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slots_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         slots_ff     <= slots_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Item and result payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         func_ff  <= req_func;
         idx_ff   <= req_handle_index;
         gen_ff   <= req_handle_generation;
         world_ff <= req_handle_world;
      end
      if (state_ff == ST_EXEC) begin
         pop_idx_ff <= fifo_rdata;
      end
      if (rsp_valid_in) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_index_ff    <= rsp_index_in;
         rsp_gen_ff      <= rsp_gen_in;
         rsp_world_ff    <= rsp_world_in;
         rsp_reused_ff   <= rsp_reused_in;
         rsp_is_valid_ff <= rsp_is_valid_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_out_index      = rsp_index_ff;
   assign rsp_out_generation = rsp_gen_ff;
   assign rsp_out_world      = rsp_world_ff;
   assign rsp_reused         = rsp_reused_ff;
   assign rsp_is_valid       = rsp_is_valid_ff;

   // A result never follows another in the next cycle.
   a_rsp_spaced: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back results");

   // An accepted item keeps the block busy in the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy low after accept");

   // The queue never holds more entries than there are slots.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SLOTS))
      else $error("free count out of range");

   // A reused index is only handed out as a successful allocate.
   a_reuse_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_reused) |-> (rsp_status == STATUS_OK && rsp_is_valid))
      else $error("reused result not ok");

   // A pop leaves the queue one entry shorter.
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_POP) |-> (count_ff == $past(count_ff) - CNT_W'(1)))
      else $error("pop did not shorten the queue");

endmodule

// File: rtl/core/gha_ram.sv
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Used for the generation store and the free queue; depends on nothing else.
module gha_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 12
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   localparam int DEPTH = 1 << ADDR_W;

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: verif/generational_handle_allocator_unit_tb.sv
// Self-checking testbench for the generational handle allocator unit.
// It needs gha_pkg, gha_ram and generational_handle_allocator_unit; it reads no files.
// Items are checked against a built-in predictor, register writes are read back.
module generational_handle_allocator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import gha_pkg::*;

   localparam int unsigned RUN_LIMIT     = 1_000_000;
   localparam int unsigned IDLE_SETTLE   = 4;
   localparam int unsigned RAND_PHASES   = 4;
   localparam int unsigned PHASE_ITEMS   = 420;
   localparam int unsigned DIR_ROWS      = 25;
   localparam logic [FUNC_W-1:0] FUNC_RESERVED = 2'd3;

   // One result item, field for field as on the rsp_ ports.
   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [IDX_W-1:0]    index;
      logic [GEN_W-1:0]    gen;
      logic [WORLD_W-1:0]  world;
      logic                reused;
      logic                is_valid;
   } handle_result_type;

   localparam handle_result_type NO_WANT = '0;

   typedef enum logic {ROW_ITEM, ROW_REG} row_kind_type;

   // One row of the directed table: an item or a register write.
   typedef struct {
      row_kind_type        kind;
      logic [FUNC_W-1:0]   func;
      logic [IDX_W-1:0]    idx;
      logic [GEN_W-1:0]    gen;
      logic [WORLD_W-1:0]  world;
      logic                reg_sel;
      logic [PDATA_W-1:0]  reg_data;
      logic                typed;
      handle_result_type   want;
   } stim_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   logic [FUNC_W-1:0]    req_func = '0;
   logic [IDX_W-1:0]     req_handle_index = '0;
   logic [GEN_W-1:0]     req_handle_generation = '0;
   logic [WORLD_W-1:0]   req_handle_world = '0;
   logic                 rsp_valid;
   logic [STATUS_W-1:0]  rsp_status;
   logic [IDX_W-1:0]     rsp_out_index;
   logic [GEN_W-1:0]     rsp_out_generation;
   logic [WORLD_W-1:0]   rsp_out_world;
   logic                 rsp_reused;
   logic                 rsp_is_valid;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [PADDR_W-1:0]   paddr = '0;
   logic [PDATA_W-1:0]   pwdata = '0;
   logic [PDATA_W-1:0]   prdata;
   logic                 pready;

   // Predictor state: generation per slot, queue of freed indices, registers.
   logic [GEN_W-1:0]     gen_mem [MAX_SLOTS];
   logic [IDX_W-1:0]     freed_q [$];
   int unsigned          slots_made = 0;
   logic [WORLD_W-1:0]   cur_world = '0;
   logic [CNT_W-1:0]     cur_threshold = THRESH_RESET;

   handle_result_type    predicted_results [$];
   int unsigned          mismatch_count = 0;
   int unsigned          result_count = 0;
   int unsigned          item_count = 0;
   int unsigned          reuse_count = 0;
   int unsigned          full_count = 0;
   int unsigned          reg_writes = 0;
   int unsigned          cycle_count = 0;
   int unsigned          burst_left = 0;

   // Directed table: typed expectations only where they are plain to see.
   stim_row_type directed_rows [DIR_ROWS] = '{
      // Fresh after reset: nothing is valid yet.
      '{ROW_ITEM, FUNC_CHECK, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, FUNC_DEALLOC, 12'd4095, 8'd255, 8'd255, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd4095, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
      '{ROW_ITEM, FUNC_ALLOC, 12'd4095, 8'd255, 8'd255, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd1, 8'd0, 8'd0, 1'b0, 1'b1}},
      // Check against each of world, index bound and generation.
      '{ROW_ITEM, FUNC_CHECK, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
      '{ROW_ITEM, FUNC_CHECK, 12'd0, 8'd0, 8'd255, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, FUNC_CHECK, 12'd1, 8'd255, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd1, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, FUNC_CHECK, 12'd2, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd2, 8'd0, 8'd0, 1'b0, 1'b0}},
      // Free a handle, then try the stale copy again.
      '{ROW_ITEM, FUNC_DEALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
      '{ROW_ITEM, FUNC_DEALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd0, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, FUNC_CHECK, 12'd0, 8'd1, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd0, 8'd0, 8'd0, 1'b0, 1'b1}},
      '{ROW_ITEM, FUNC_RESERVED, 12'd4095, 8'd255, 8'd255, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd4095, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b0, NO_WANT},
      // Threshold zero: reuse at once, fall back to fresh when the queue is empty.
      '{ROW_REG, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_REUSE_THRESHOLD, 32'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd0, 8'd1, 8'd0, 1'b1, 1'b1}},
      '{ROW_ITEM, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd3, 8'd0, 8'd0, 1'b0, 1'b1}},
      '{ROW_REG, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd255, 1'b0, NO_WANT},
      '{ROW_ITEM, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd4, 8'd0, 8'd255, 1'b0, 1'b1}},
      '{ROW_ITEM, FUNC_CHECK, 12'd4, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_INVALID, 12'd4, 8'd0, 8'd0, 1'b0, 1'b0}},
      '{ROW_ITEM, FUNC_DEALLOC, 12'd4, 8'd0, 8'd255, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd4, 8'd0, 8'd0, 1'b0, 1'b1}},
      '{ROW_ITEM, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b1,
        '{STATUS_OK, 12'd4, 8'd1, 8'd255, 1'b1, 1'b1}},
      // Threshold 4096, the slot count: freed indices wait in the queue.
      '{ROW_REG, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_REUSE_THRESHOLD, 32'd4096, 1'b0,
        NO_WANT},
      '{ROW_ITEM, FUNC_DEALLOC, 12'd3, 8'd0, 8'd255, REG_WORLD_ID, 32'd0, 1'b0, NO_WANT},
      '{ROW_ITEM, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b0, NO_WANT},
      '{ROW_REG, FUNC_ALLOC, 12'd0, 8'd0, 8'd0, REG_WORLD_ID, 32'd0, 1'b0, NO_WANT}
   };

   generational_handle_allocator_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_func              (req_func),
      .req_handle_index      (req_handle_index),
      .req_handle_generation (req_handle_generation),
      .req_handle_world      (req_handle_world),
      .rsp_valid             (rsp_valid),
      .rsp_status            (rsp_status),
      .rsp_out_index         (rsp_out_index),
      .rsp_out_generation    (rsp_out_generation),
      .rsp_out_world         (rsp_out_world),
      .rsp_reused            (rsp_reused),
      .rsp_is_valid          (rsp_is_valid),
      .psel                  (psel),
      .penable               (penable),
      .pwrite                (pwrite),
      .paddr                 (paddr),
      .pwdata                (pwdata),
      .prdata                (prdata),
      .pready                (pready)
   );

   // Clock with a 4 ns period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Run limit; a hung handshake ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("generational_handle_allocator_unit: mismatch");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("[%0t] %s", $realtime, msg);
   endtask

   // Applies one item to the predictor state and returns the result it should give.
   function automatic handle_result_type predict_handle_op(input logic [FUNC_W-1:0] op,
                                                           input logic [IDX_W-1:0] idx,
                                                           input logic [GEN_W-1:0] gen,
                                                           input logic [WORLD_W-1:0] world);
      handle_result_type res;
      logic live;
      res = '{status: STATUS_INVALID, index: idx, gen: '0, world: '0,
              reused: 1'b0, is_valid: 1'b0};
      live = (world == cur_world) && (idx < slots_made) && (gen == gen_mem[idx]);
      case (op)
         FUNC_ALLOC: begin
            if ((freed_q.size() < cur_threshold || freed_q.size() == 0) &&
                slots_made < MAX_SLOTS) begin
               res.index = IDX_W'(slots_made);
               gen_mem[slots_made] = '0;
               slots_made++;
               res.status = STATUS_OK;
            end else if (freed_q.size() != 0) begin
               res.index = freed_q.pop_front();
               res.gen = gen_mem[res.index];
               res.reused = 1'b1;
               res.status = STATUS_OK;
            end else begin
               res.status = STATUS_FULL;
            end
            if (res.status == STATUS_OK) begin
               res.world = cur_world;
               res.is_valid = 1'b1;
            end
         end
         FUNC_DEALLOC: begin
            if (!live) begin
               res.status = STATUS_INVALID;
            end else if (freed_q.size() >= MAX_SLOTS) begin
               res.status = STATUS_FULL;
               res.is_valid = 1'b1;
            end else begin
               freed_q.push_back(idx);
               gen_mem[idx] = gen_mem[idx] + 1'b1;
               res.status = STATUS_OK;
               res.is_valid = 1'b1;
            end
         end
         FUNC_CHECK: begin
            res.is_valid = live;
            res.status = live ? STATUS_OK : STATUS_INVALID;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Gap before the next item: mostly none or short, a few long, with bursts of none.
   function automatic int unsigned pick_gap();
      int unsigned r;
      if (burst_left != 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(99);
      if (r < 3) begin
         burst_left = $urandom_range(60, 20);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(24, 16);
   endfunction

   // Drives one item, waits for it to be taken and records its expected result.
   task automatic issue_item(input logic [FUNC_W-1:0] op, input logic [IDX_W-1:0] idx,
                             input logic [GEN_W-1:0] gen, input logic [WORLD_W-1:0] world,
                             input logic typed, input handle_result_type want);
      int unsigned gap;
      handle_result_type predicted;
      gap = pick_gap();
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= op;
      req_handle_index <= idx;
      req_handle_generation <= gen;
      req_handle_world <= world;
      // Sample busy mid-cycle; the item is taken at the following edge.
      do @(negedge clock); while (busy !== 1'b0);
      @(posedge clock);
      predicted = predict_handle_op(op, idx, gen, world);
      predicted_results.push_back(typed ? want : predicted);
      item_count++;
      if (predicted.reused) reuse_count++;
      if (predicted.status == STATUS_FULL) full_count++;
   endtask

   // Lets every pending result drain and the block fall idle.
   task automatic wait_idle();
      start <= 1'b0;
      do @(negedge clock); while (predicted_results.size() != 0 || busy !== 1'b0);
      repeat (IDLE_SETTLE) @(posedge clock);
   endtask

   // Writes one register over the APB port, then reads it back.
   task automatic csr_access(input logic sel, input logic [PDATA_W-1:0] value);
      logic [PDATA_W-1:0] mask;
      logic [PDATA_W-1:0] readback;
      mask = (sel == REG_WORLD_ID) ? PDATA_W'(8'hFF) : PDATA_W'(13'h1FFF);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (pready !== 1'b1);
      @(posedge clock);
      if (sel == REG_WORLD_ID) cur_world = value[WORLD_W-1:0];
      else cur_threshold = value[CNT_W-1:0];
      reg_writes++;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (pready !== 1'b1);
      readback = prdata;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      if ((readback & mask) !== (value & mask))
         report_mismatch($sformatf("register %0d read back 0x%0h, wrote 0x%0h",
                                   sel, readback, value));
   endtask

   // Handle fields: mostly a live handle, some with one bit flipped, some noise.
   task automatic pick_handle(output logic [IDX_W-1:0] idx, output logic [GEN_W-1:0] gen,
                              output logic [WORLD_W-1:0] world);
      int unsigned r;
      r = $urandom_range(99);
      if (slots_made != 0 && r < 70) begin
         idx = IDX_W'($urandom_range(slots_made - 1));
         gen = gen_mem[idx];
         world = cur_world;
         if (r >= 50) begin
            case ($urandom_range(2))
               0: idx = idx ^ (IDX_W'(1) << $urandom_range(IDX_W - 1));
               1: gen = gen ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
               default: world = world ^ (WORLD_W'(1) << $urandom_range(WORLD_W - 1));
            endcase
         end
      end else begin
         idx = IDX_W'($urandom_range(MAX_SLOTS - 1));
         gen = GEN_W'($urandom_range(255));
         world = WORLD_W'($urandom_range(255));
      end
   endtask

   // One random item across all operations, unused code included.
   task automatic random_item();
      int unsigned r;
      logic [IDX_W-1:0] idx;
      logic [GEN_W-1:0] gen;
      logic [WORLD_W-1:0] world;
      r = $urandom_range(99);
      pick_handle(idx, gen, world);
      if (r < 40) issue_item(FUNC_ALLOC, idx, gen, world, 1'b0, NO_WANT);
      else if (r < 75) issue_item(FUNC_DEALLOC, idx, gen, world, 1'b0, NO_WANT);
      else if (r < 95) issue_item(FUNC_CHECK, idx, gen, world, 1'b0, NO_WANT);
      else issue_item(FUNC_RESERVED, idx, gen, world, 1'b0, NO_WANT);
   endtask

   // Result checker: every strobed result against the oldest expectation.
   always @(negedge clock) begin
      handle_result_type want;
      if (!reset && rsp_valid === 1'b1) begin
         result_count++;
         if (predicted_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with nothing pending",
                                      result_count));
         end else begin
            want = predicted_results.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                         result_count, rsp_status, want.status));
            if (rsp_out_index !== want.index)
               report_mismatch($sformatf("result %0d index %0d, expected %0d",
                                         result_count, rsp_out_index, want.index));
            if (rsp_out_generation !== want.gen)
               report_mismatch($sformatf("result %0d generation %0d, expected %0d",
                                         result_count, rsp_out_generation, want.gen));
            if (rsp_out_world !== want.world)
               report_mismatch($sformatf("result %0d world %0d, expected %0d",
                                         result_count, rsp_out_world, want.world));
            if (rsp_reused !== want.reused)
               report_mismatch($sformatf("result %0d reused %0d, expected %0d",
                                         result_count, rsp_reused, want.reused));
            if (rsp_is_valid !== want.is_valid)
               report_mismatch($sformatf("result %0d is_valid %0d, expected %0d",
                                         result_count, rsp_is_valid, want.is_valid));
         end
      end
   end

   // Main sequence.
   initial begin
      logic [WORLD_W-1:0] world;
      logic [CNT_W-1:0] thresh;

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed table.
      for (int row = 0; row < DIR_ROWS; row++) begin
         if (directed_rows[row].kind == ROW_REG) begin
            wait_idle();
            csr_access(directed_rows[row].reg_sel, directed_rows[row].reg_data);
         end else begin
            issue_item(directed_rows[row].func, directed_rows[row].idx,
                       directed_rows[row].gen, directed_rows[row].world,
                       directed_rows[row].typed, directed_rows[row].want);
         end
      end

      // Random phases, each under its own world number and threshold.
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         case (phase)
            0: begin world = 8'hFF; thresh = 13'd1; end
            1: begin world = 8'h00; thresh = 13'd0; end
            2: begin world = WORLD_W'($urandom_range(254, 1));
                     thresh = CNT_W'($urandom_range(64, 2)); end
            default: begin world = WORLD_W'($urandom_range(255));
                           thresh = CNT_W'(MAX_SLOTS); end
         endcase
         wait_idle();
         csr_access(REG_WORLD_ID, PDATA_W'(world));
         csr_access(REG_REUSE_THRESHOLD, PDATA_W'(thresh));
         repeat (PHASE_ITEMS) random_item();
      end

      wait_idle();
      repeat (10) @(posedge clock);
      $display("Run covered %0d items and %0d register writes over four thresholds,",
               item_count, reg_writes);
      $display("%0d of them reused a freed index and %0d found no room.",
               reuse_count, full_count);
      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("generational_handle_allocator_unit: match");
      end else begin
         $display("generational_handle_allocator_unit: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/gha_pkg.sv
rtl/core/gha_ram.sv
rtl/core/generational_handle_allocator_unit.sv
verif/generational_handle_allocator_unit_tb.sv
